>>> sv/scrt_pkg.sv
// Shared types and codes for the snapshot chunk remap table.
package scrt_pkg;

   localparam int KindW   = 2;
   localparam int StatusW = 2;
   localparam int DevW    = 16;
   localparam int SecW    = 32;
   localparam int IdxW    = 10;
   localparam int ChunkW  = 16;
   localparam int LimitW  = 11;
   localparam int CsrIdxW = 1;
   localparam int CsrW    = 16;
   localparam int DivW    = 17;

   localparam logic [KindW-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KindW-1:0] KIND_RECORD = 2'd1;
   localparam logic [KindW-1:0] KIND_LOAD   = 2'd2;

   localparam logic [StatusW-1:0] ST_OK      = 2'd0;
   localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
   localparam logic [StatusW-1:0] ST_DROPPED = 2'd2;

   localparam logic [CsrIdxW-1:0] CSR_CHUNK = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_LIMIT = 1'd1;

   typedef struct packed {
      logic [SecW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [SecW-1:0] quot;
      logic [DivW-1:0] rem;
   } div_rsp_type;

endpackage

>>> sv/snapshot_chunk_remap_table.sv
// Snapshot exception table: chunk remap lookup, record and target load.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser kind, tdata device..target_sector
//  rsp     | out | rsp_tvalid/tready    | tuser hit,status, tdata device,sector
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// Lookups and records run three passes of the shared divider (offset,
// alignment, chunk number); a bucket count that is not a power of two adds
// a fourth pass for the bucket. A lookup then reads the bucket head and walks
// the chain one entry at a time; a hit reads the target, and a hit that is
// not at the chain head is first moved there. Loads and items after a drop
// go straight to the result. Each table RAM has one read port.
// Reset clears the bucket valid bits, fill pointer and drop flag.
// One item is in flight; a finished result waits in the rsp register.
module snapshot_chunk_remap_table #(
   parameter int ENTRIES      = 1024,
   parameter int HASH_BUCKETS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // device, sector, extent_start, entry_index, target_device, target_sector, pad
   input  logic [143:0]                    req_tdata,
   // kind
   input  logic [scrt_pkg::KindW-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_device, out_sector
   output logic [47:0]                     rsp_tdata,
   // hit, status
   output logic [2:0]                      rsp_tuser,
   input  logic                            csr_we,
   input  logic [scrt_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [scrt_pkg::CsrW-1:0]       csr_wdata
);
   import scrt_pkg::*;

   localparam int AW  = $clog2(ENTRIES);
   localparam int LW  = AW + 1;
   localparam int BW  = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
   localparam int BD  = (HASH_BUCKETS > 1) ? HASH_BUCKETS : 2;
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);
   localparam int OW  = DevW + SecW;
   localparam bit BktPow2 = ((HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DIV   = 10'b0000000010,
      S_HEAD  = 10'b0000000100,
      S_HEADW = 10'b0000001000,
      S_WALK  = 10'b0000010000,
      S_CMP   = 10'b0000100000,
      S_MTF   = 10'b0001000000,
      S_TGT   = 10'b0010000000,
      S_TGTW  = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [ChunkW-1:0] chunk_ff;
   logic [LimitW-1:0] limit_ff;
   logic              dropped_ff, dropped_in;
   logic [LW-1:0]     fill_ff, fill_in;
   logic [BD-1:0]     head_vld_ff;

   // item registers
   logic [KindW-1:0]  kind_ff;
   logic [DevW-1:0]   dev_ff;
   logic [SecW-1:0]   sec_ff, adj_ff, adj_in, start_ff, start_in;
   logic [1:0]        phase_ff, phase_in;
   logic [BW-1:0]     bkt_ff, bkt_in;
   logic [LW-1:0]     head_ff, head_in, cur_ff, cur_in, prev_ff, prev_in;

   logic              res_hit_ff, res_hit_in;
   logic [DevW-1:0]   res_dev_ff, res_dev_in;
   logic [SecW-1:0]   res_sec_ff, res_sec_in;
   logic [StatusW-1:0] res_st_ff, res_st_in;

   logic              rsp_valid_ff;
   logic [47:0]       rsp_data_ff;
   logic [2:0]        rsp_user_ff;

   logic [DevW-1:0]   in_dev, in_tdev;
   logic [SecW-1:0]   in_sec, in_ext, in_tsec;
   logic [IdxW-1:0]   in_idx;
   logic              accept;
   logic [DivW-1:0]   eff_chunk;
   logic [31:0]       lim;
   logic [SecW-1:0]   bkt_hash;
   logic              rec_full;

   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic              div_go;

   // RAM ports
   logic              orig_we, tgt_we, chain_we, head_we;
   logic [AW-1:0]     orig_waddr, tgt_waddr, chain_waddr, orig_raddr, tgt_raddr, chain_raddr;
   logic [OW-1:0]     orig_wdata, tgt_wdata, orig_rdata, tgt_rdata;
   logic [LW-1:0]     chain_wdata, chain_rdata, head_wdata, head_rdata;
   logic [BW-1:0]     head_waddr, head_raddr;

   assign in_dev  = req_tdata[15:0];
   assign in_sec  = req_tdata[47:16];
   assign in_ext  = req_tdata[79:48];
   assign in_idx  = req_tdata[89:80];
   assign in_tdev = req_tdata[105:90];
   assign in_tsec = req_tdata[137:106];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign eff_chunk  = (chunk_ff == '0) ? DivW'(1) : {1'b0, chunk_ff};
   assign lim        = (32'(limit_ff) < 32'(ENTRIES)) ? 32'(limit_ff) : 32'(ENTRIES);
   assign bkt_hash   = {{(SecW-DevW){1'b0}}, dev_ff} ^ div_rsp.quot;
   assign rec_full   = (kind_ff == KIND_RECORD) && (32'(fill_ff) >= lim);

   scrt_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   scrt_ram #(.WIDTH(OW), .DEPTH(ENTRIES)) u_orig_ram (
      .clock(clock), .we(orig_we), .waddr(orig_waddr), .wdata(orig_wdata),
      .raddr(orig_raddr), .rdata(orig_rdata)
   );

   scrt_ram #(.WIDTH(OW), .DEPTH(ENTRIES)) u_tgt_ram (
      .clock(clock), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
      .raddr(tgt_raddr), .rdata(tgt_rdata)
   );

   scrt_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_chain_ram (
      .clock(clock), .we(chain_we), .waddr(chain_waddr), .wdata(chain_wdata),
      .raddr(chain_raddr), .rdata(chain_rdata)
   );

   scrt_ram #(.WIDTH(LW), .DEPTH(BD)) u_head_ram (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      fill_in    = fill_ff;
      phase_in   = phase_ff;
      adj_in     = adj_ff;
      start_in   = start_ff;
      bkt_in     = bkt_ff;
      head_in    = head_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      res_hit_in = res_hit_ff;
      res_dev_in = res_dev_ff;
      res_sec_in = res_sec_ff;
      res_st_in  = res_st_ff;
      div_go     = 1'b0;
      div_req.dividend = in_ext;
      div_req.divisor  = eff_chunk;

      orig_we     = 1'b0;
      orig_waddr  = fill_ff[AW-1:0];
      orig_wdata  = {start_ff, dev_ff};
      orig_raddr  = cur_ff[AW-1:0];
      tgt_we      = 1'b0;
      tgt_waddr   = AW'(in_idx);
      tgt_wdata   = {in_tsec, in_tdev};
      tgt_raddr   = cur_ff[AW-1:0];
      chain_we    = 1'b0;
      chain_waddr = fill_ff[AW-1:0];
      chain_wdata = head_ff;
      chain_raddr = cur_ff[AW-1:0];
      head_we     = 1'b0;
      head_waddr  = bkt_ff;
      head_wdata  = fill_ff;
      head_raddr  = bkt_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_hit_in = 1'b0;
               res_dev_in = in_dev;
               res_sec_in = in_sec;
               res_st_in  = ST_OK;
               if (dropped_ff) begin
                  res_st_in = ST_DROPPED;
                  state_in  = S_FIN;
               end else if (req_tuser == KIND_LOOKUP || req_tuser == KIND_RECORD) begin
                  div_go   = 1'b1;
                  phase_in = 2'd0;
                  state_in = S_DIV;
               end else begin
                  tgt_we   = (req_tuser == KIND_LOAD) && (32'(in_idx) < 32'(ENTRIES));
                  state_in = S_FIN;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               phase_in = phase_ff + 2'd1;
               case (phase_ff)
                  2'd0: begin
                     div_go = 1'b1;
                     div_req.dividend = sec_ff - SecW'(div_rsp.rem);
                  end
                  2'd1: begin
                     adj_in   = SecW'(div_rsp.rem);
                     start_in = sec_ff - SecW'(div_rsp.rem);
                     div_go   = 1'b1;
                     div_req.dividend = sec_ff - SecW'(div_rsp.rem);
                  end
                  2'd2: begin
                     if (BktPow2) begin
                        // power-of-two bucket count: the bucket is the low hash bits
                        bkt_in = (HASH_BUCKETS > 1) ? bkt_hash[BW-1:0] : '0;
                        if (rec_full) begin
                           dropped_in = 1'b1;
                           res_st_in  = ST_FULL;
                           state_in   = S_FIN;
                        end else begin
                           state_in = S_HEAD;
                        end
                     end else begin
                        div_go = 1'b1;
                        div_req.dividend = bkt_hash;
                        div_req.divisor  = DivW'(HASH_BUCKETS);
                     end
                  end
                  default: begin
                     bkt_in = div_rsp.rem[BW-1:0];
                     if (rec_full) begin
                        dropped_in = 1'b1;
                        res_st_in  = ST_FULL;
                        state_in   = S_FIN;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
               endcase
            end
         end
         S_HEAD: begin
            state_in = S_HEADW;
         end
         S_HEADW: begin
            head_in = head_vld_ff[bkt_ff] ? head_rdata : NIL;
            if (kind_ff == KIND_RECORD) begin
               orig_we     = 1'b1;
               chain_we    = 1'b1;
               chain_wdata = head_vld_ff[bkt_ff] ? head_rdata : NIL;
               head_we     = 1'b1;
               fill_in     = fill_ff + 1'b1;
               state_in    = S_FIN;
            end else begin
               cur_in  = head_vld_ff[bkt_ff] ? head_rdata : NIL;
               prev_in = NIL;
               state_in = head_vld_ff[bkt_ff] && head_rdata != NIL ? S_WALK : S_FIN;
            end
         end
         S_WALK: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (orig_rdata == {start_ff, dev_ff}) begin
               if (prev_ff != NIL) begin
                  chain_we    = 1'b1;
                  chain_waddr = prev_ff[AW-1:0];
                  chain_wdata = chain_rdata;
                  state_in    = S_MTF;
               end else begin
                  state_in = S_TGT;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = chain_rdata;
               state_in = (chain_rdata == NIL) ? S_FIN : S_WALK;
            end
         end
         S_MTF: begin
            // move the hit entry to the chain head
            chain_we    = 1'b1;
            chain_waddr = cur_ff[AW-1:0];
            chain_wdata = head_ff;
            head_we     = 1'b1;
            head_wdata  = cur_ff;
            state_in    = S_TGT;
         end
         S_TGT: begin
            state_in = S_TGTW;
         end
         S_TGTW: begin
            res_hit_in = 1'b1;
            res_dev_in = tgt_rdata[DevW-1:0];
            res_sec_in = tgt_rdata[OW-1:DevW] + adj_ff;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dropped_ff   <= 1'b0;
         fill_ff      <= '0;
         head_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= ChunkW'(16);
         limit_ff     <= LimitW'(1024);
         phase_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
         fill_ff    <= fill_in;
         phase_ff   <= phase_in;
         if (head_we) begin
            head_vld_ff[head_waddr] <= 1'b1;
         end
         if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CHUNK: chunk_ff <= csr_wdata;
               CSR_LIMIT: limit_ff <= csr_wdata[LimitW-1:0];
               default:   ;
            endcase
         end
      end
      if (accept) begin
         kind_ff <= req_tuser;
         dev_ff  <= in_dev;
         sec_ff  <= in_sec;
      end
      adj_ff     <= adj_in;
      start_ff   <= start_in;
      bkt_ff     <= bkt_in;
      head_ff    <= head_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      res_hit_ff <= res_hit_in;
      res_dev_ff <= res_dev_in;
      res_sec_ff <= res_sec_in;
      res_st_ff  <= res_st_in;
      if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {res_sec_ff, res_dev_ff};
         rsp_user_ff <= {res_st_ff, res_hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |=> dropped_ff) else $error("drop flag cleared");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(ENTRIES)) else $error("fill pointer overrun");
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[0] |-> rsp_user_ff[2:1] == ST_OK)
      else $error("hit with bad status");
endmodule

>>> sv/scrt_ram.sv
// Generic single write, single read RAM with registered read data.
module scrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/scrt_div.sv
// Shared restoring divider, one quotient bit per cycle.
module scrt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  scrt_pkg::div_req_type     req,
   output scrt_pkg::div_rsp_type     rsp
);
   import scrt_pkg::*;

   localparam int CntW = $clog2(SecW);

   logic [SecW-1:0] quot_ff, quot_in;
   logic [DivW-1:0] rem_ff, rem_in, dvs_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[SecW-1]};
      if (go) begin
         quot_in = req.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = DivW'(trial - {1'b0, dvs_ff});
            quot_in = {quot_ff[SecW-2:0], 1'b1};
         end else begin
            rem_in  = trial[DivW-1:0];
            quot_in = {quot_ff[SecW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(SecW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (go) begin
         dvs_ff <= req.divisor;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;
endmodule
